[rtl/core/aes_ctr_pkg.sv]
package aes_ctr_pkg;

    localparam int BLOCK_W   = 128;
    localparam int LEN_W     = 5;
    localparam int ROUNDS    = 10;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_UPPER = 2'd0,
        REG_KEY_LOWER = 2'd1,
        REG_IV_UPPER  = 2'd2,
        REG_IV_LOWER  = 2'd3
    } cfg_reg_t;

    // one classified chunk waiting for its keystream block
    typedef struct packed {
        logic [BLOCK_W-1:0] data;
        logic [LEN_W-1:0]   nbytes;
    } chunk_t;

    typedef logic [7:0] byte_t;

    localparam byte_t SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t RCON [ROUNDS] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic byte_t xtime(input byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // bytes numbered as in the standard: byte 0 in bits 127:120
    function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] o;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[BLOCK_W-1-8*(r+4*c) -: 8] =
                    SBOX[s[BLOCK_W-1-8*(r+4*((c+r)%4)) -: 8]];
            end
        end
        return o;
    endfunction

    function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] o;
        byte_t a0, a1, a2, a3, all;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[BLOCK_W-1-32*c -: 8];
            a1 = s[BLOCK_W-9-32*c -: 8];
            a2 = s[BLOCK_W-17-32*c -: 8];
            a3 = s[BLOCK_W-25-32*c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            o[BLOCK_W-1-32*c -: 8]  = a0 ^ all ^ xtime(a0 ^ a1);
            o[BLOCK_W-9-32*c -: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
            o[BLOCK_W-17-32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            o[BLOCK_W-25-32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return o;
    endfunction

    function automatic logic [BLOCK_W-1:0] next_round_key(input logic [BLOCK_W-1:0] k,
                                                          input byte_t rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

[rtl/core/aes_ctr_front.sv]
// Accepts chunks, keeps the counter, and issues one counter block per chunk.
module aes_ctr_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [aes_ctr_pkg::BLOCK_W-1:0]     in_data,
    input  logic [aes_ctr_pkg::LEN_W-1:0]       in_nbytes,
    input  logic                                in_start,
    input  logic [aes_ctr_pkg::BLOCK_W-1:0]     iv,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [aes_ctr_pkg::BLOCK_W-1:0]     out_ctr,
    output aes_ctr_pkg::chunk_t                 out_chunk
);
    logic [aes_ctr_pkg::BLOCK_W-1:0] ctr_reg, ctr_next, ctr_use;
    logic [aes_ctr_pkg::BLOCK_W-1:0] oct_reg;
    aes_ctr_pkg::chunk_t              och_reg;
    logic                             ov_reg;
    logic [aes_ctr_pkg::LEN_W-1:0]    n_sat;
    logic                             take;

    assign in_ready  = !ov_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_ctr   = oct_reg;
    assign out_chunk = och_reg;

    always_comb begin
        ctr_use  = in_start ? iv : ctr_reg;
        ctr_next = ctr_use + aes_ctr_pkg::BLOCK_W'(1);
        if (in_nbytes == '0) begin
            n_sat = aes_ctr_pkg::LEN_W'(1);
        end else if (in_nbytes > aes_ctr_pkg::LEN_W'(16)) begin
            n_sat = aes_ctr_pkg::LEN_W'(16);
        end else begin
            n_sat = in_nbytes;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            if (take) begin
                ctr_reg <= ctr_next;
            end
            if (in_ready) begin
                ov_reg <= in_valid;
            end
        end
        if (take) begin
            oct_reg        <= ctr_use;
            och_reg.data   <= in_data;
            och_reg.nbytes <= n_sat;
        end
    end
endmodule

[rtl/core/aes_ctr_fifo.sv]
// Short queue between front and back.
module aes_ctr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;
    logic             wr, rd;

    assign in_ready  = cnt_reg != (AW+1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data  = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + AW'(1);
            end
            if (rd) begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
        if (wr) begin
            mem_reg[wp_reg] <= in_data;
        end
    end
endmodule

[rtl/core/aes_ctr_back.sv]
// Ten-stage round pipeline with the key schedule carried alongside, then
// the XOR, length mask and output register.
module aes_ctr_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [aes_ctr_pkg::BLOCK_W-1:0]  key,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [aes_ctr_pkg::BLOCK_W-1:0]  in_ctr,
    input  aes_ctr_pkg::chunk_t              in_chunk,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [aes_ctr_pkg::BLOCK_W-1:0]  out_text,
    output logic [aes_ctr_pkg::LEN_W-1:0]    out_nbytes
);
    localparam int R = aes_ctr_pkg::ROUNDS;
    localparam int BW = aes_ctr_pkg::BLOCK_W;

    logic [BW-1:0]       st_reg  [R+1];
    logic [BW-1:0]       rk_reg  [R+1];
    aes_ctr_pkg::chunk_t ch_reg  [R+1];
    logic [R:0]          v_reg;
    logic                adv;
    logic [BW-1:0]       mask;
    logic [BW-1:0]       txt_reg;
    logic [aes_ctr_pkg::LEN_W-1:0] nb_reg;
    logic                ov_reg;

    // whole pipe stalls together when the output register is held
    assign adv       = !ov_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = ov_reg;
    assign out_text  = txt_reg;
    assign out_nbytes = nb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end else if (adv) begin
            v_reg  <= {v_reg[R-1:0], in_valid};
            ov_reg <= v_reg[R];
        end
        if (adv) begin
            st_reg[0] <= in_ctr ^ key;
            rk_reg[0] <= key;
            ch_reg[0] <= in_chunk;
            for (int i = 1; i <= R; i++) begin
                logic [BW-1:0] k, s;
                k = aes_ctr_pkg::next_round_key(rk_reg[i-1], aes_ctr_pkg::RCON[i-1]);
                s = aes_ctr_pkg::sub_shift(st_reg[i-1]);
                if (i != R) begin
                    s = aes_ctr_pkg::mix_columns(s);
                end
                st_reg[i] <= s ^ k;
                rk_reg[i] <= k;
                ch_reg[i] <= ch_reg[i-1];
            end
            txt_reg <= (ch_reg[R].data ^ st_reg[R]) & mask;
            nb_reg  <= ch_reg[R].nbytes;
        end
    end

    always_comb begin
        for (int b = 0; b < 16; b++) begin
            mask[BW-1-8*b -: 8] = (aes_ctr_pkg::LEN_W'(b) < ch_reg[R].nbytes) ? 8'hff : 8'h00;
        end
    end
endmodule

[rtl/core/aes128_ctr_stream_cipher.sv]
// Path from an input transaction to its result: front register, two-entry queue,
// initial key-add register, ten AES round stages plus output register.
// Throughput: one 128-bit chunk per cycle while m_tready is held high, set by the fully unrolled round pipe.
// Reset: aresetn synchronous, active low; clears key, IV, counter and all valids.
module aes128_ctr_stream_cipher (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // chunk_upper[63:0], chunk_lower[127:64], chunk_bytes[132:128]
    input  logic         s_tuser,   // start_message
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // text_upper[63:0], text_lower[127:64], text_bytes[132:128]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    logic [63:0] ku_reg, kl_reg, ivu_reg, ivl_reg;
    logic        f_v, f_r, b_v, b_r;
    logic [aes_ctr_pkg::BLOCK_W-1:0] f_ctr, q_ctr, txt;
    aes_ctr_pkg::chunk_t f_ch, q_ch;
    logic [aes_ctr_pkg::LEN_W-1:0] nb;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ku_reg <= '0;
            kl_reg <= '0;
            ivu_reg <= '0;
            ivl_reg <= '0;
        end else if (cfg_valid) begin
            unique case (aes_ctr_pkg::cfg_reg_t'(cfg_index))
                aes_ctr_pkg::REG_KEY_UPPER: ku_reg  <= cfg_data;
                aes_ctr_pkg::REG_KEY_LOWER: kl_reg  <= cfg_data;
                aes_ctr_pkg::REG_IV_UPPER:  ivu_reg <= cfg_data;
                aes_ctr_pkg::REG_IV_LOWER:  ivl_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    aes_ctr_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_data({s_tdata[63:0], s_tdata[127:64]}),
        .in_nbytes(s_tdata[132:128]), .in_start(s_tuser),
        .iv({ivu_reg, ivl_reg}),
        .out_valid(f_v), .out_ready(f_r), .out_ctr(f_ctr), .out_chunk(f_ch)
    );

    aes_ctr_fifo #(
        .WIDTH(aes_ctr_pkg::BLOCK_W + $bits(aes_ctr_pkg::chunk_t)), .DEPTH(2)
    ) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_v), .in_ready(f_r), .in_data({f_ctr, f_ch}),
        .out_valid(b_v), .out_ready(b_r), .out_data({q_ctr, q_ch})
    );

    aes_ctr_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .key({ku_reg, kl_reg}),
        .in_valid(b_v), .in_ready(b_r), .in_ctr(q_ctr), .in_chunk(q_ch),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_text(txt), .out_nbytes(nb)
    );

    assign m_tdata = {3'b000, nb, txt[63:0], txt[127:64]};
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    // Reference cipher: own AES-128 model, byte 0 of a block in bits 127:120.
    class ctr_scoreboard;
        logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
        logic [127:0] counter;
        logic [132:0] pending_text[$];
        int           errors;
        int           checked;

        function new();
            key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
            counter = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(aes_ctr_pkg::cfg_reg_t idx, logic [63:0] val);
            case (idx)
                aes_ctr_pkg::REG_KEY_UPPER: key_hi = val;
                aes_ctr_pkg::REG_KEY_LOWER: key_lo = val;
                aes_ctr_pkg::REG_IV_UPPER:  iv_hi = val;
                aes_ctr_pkg::REG_IV_LOWER:  iv_lo = val;
            endcase
        endfunction

        function logic [7:0] gdbl(logic [7:0] x);
            return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        endfunction

        function logic [127:0] encrypt(logic [127:0] blk);
            logic [7:0] rk[176];
            logic [7:0] s[16];
            logic [7:0] t[16];
            logic [7:0] w[4];
            logic [7:0] f, a0, a1, a2, a3, all;
            logic [127:0] k, o;
            k = {key_hi, key_lo};
            for (int i = 0; i < 16; i++) rk[i] = k[127-8*i -: 8];
            for (int i = 4; i < 44; i++) begin
                for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
                if (i % 4 == 0) begin
                    f = w[0];
                    w[0] = aes_ctr_pkg::SBOX[w[1]] ^ aes_ctr_pkg::RCON[i/4-1];
                    w[1] = aes_ctr_pkg::SBOX[w[2]];
                    w[2] = aes_ctr_pkg::SBOX[w[3]];
                    w[3] = aes_ctr_pkg::SBOX[f];
                end
                for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ w[j];
            end
            for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ rk[i];
            for (int rnd = 1; rnd <= 10; rnd++) begin
                for (int i = 0; i < 16; i++) t[i] = aes_ctr_pkg::SBOX[s[i]];
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++) s[r+4*c] = t[r+4*((c+r)%4)];
                if (rnd != 10) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        all = a0 ^ a1 ^ a2 ^ a3;
                        s[4*c]   = a0 ^ all ^ gdbl(a0 ^ a1);
                        s[4*c+1] = a1 ^ all ^ gdbl(a1 ^ a2);
                        s[4*c+2] = a2 ^ all ^ gdbl(a2 ^ a3);
                        s[4*c+3] = a3 ^ all ^ gdbl(a3 ^ a0);
                    end
                end
                for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[16*rnd+i];
            end
            for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
            return o;
        endfunction

        function void note_chunk(logic [135:0] tdata, logic start);
            logic [127:0] data, ks, res;
            logic [4:0]   n;
            n = tdata[132:128];
            if (n == 5'd0) n = 5'd1;
            if (n > 5'd16) n = 5'd16;
            if (start) counter = {iv_hi, iv_lo};
            data = {tdata[63:0], tdata[127:64]};
            ks = encrypt(counter);
            res = '0;
            for (int i = 0; i < 16; i++)
                if (i < n) res[127-8*i -: 8] = data[127-8*i -: 8] ^ ks[127-8*i -: 8];
            counter = counter + 128'd1;
            pending_text.insert(pending_text.size(), {n, res[63:0], res[127:64]});
        endfunction

        function void check_text(logic [135:0] tdata);
            logic [132:0] exp_t;
            if (pending_text.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, tdata);
                return;
            end
            exp_t = pending_text.pop_front();
            checked++;
            if (tdata[63:0] !== exp_t[63:0]) begin
                errors++;
                $display("%0t: text_upper exp %h got %h", $time, exp_t[63:0], tdata[63:0]);
            end
            if (tdata[127:64] !== exp_t[127:64]) begin
                errors++;
                $display("%0t: text_lower exp %h got %h", $time, exp_t[127:64],
                         tdata[127:64]);
            end
            if (tdata[132:128] !== exp_t[132:128]) begin
                errors++;
                $display("%0t: text_bytes exp %0d got %0d", $time, exp_t[132:128],
                         tdata[132:128]);
            end
            if (tdata[135:133] !== 3'b0) begin
                errors++;
                $display("%0t: pad bits exp 0 got %b", $time, tdata[135:133]);
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [135:0] m_tdata;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    ctr_scoreboard sb = new();
    int  cycle_count = 0;
    int  chunks_sent = 0;
    bit  rx_hold = 0;

    always #5 aclk = ~aclk;

    aes128_ctr_stream_cipher DUT (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random wait per result, or long hold-off when requested
    initial begin
        int gap;
        forever begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
            if (gap != 0 || rx_hold) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
                while (rx_hold) @(posedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!(aresetn && m_tvalid));
            sb.check_text(m_tdata);
        end
    end

    task automatic write_cfg(aes_ctr_pkg::cfg_reg_t idx, logic [63:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic send_chunk(logic [63:0] hi, logic [63:0] lo, logic [4:0] n, logic st,
                              int gap);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {3'b0, n, lo, hi};
        s_tuser  <= st;
        do @(posedge aclk); while (!s_tready);
        sb.note_chunk({3'b0, n, lo, hi}, st);
        chunks_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_text.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_chunk(int gap);
        logic [4:0] n;
        case ($urandom_range(0, 5))
            0: n = 5'd16;
            1: n = 5'($urandom_range(0, 31));
            default: n = 5'($urandom_range(1, 16));
        endcase
        send_chunk(rand64(), rand64(), n, $urandom_range(0, 9) == 0, gap);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // no start mark after reset: counter runs from zero with the zero key
        send_chunk('0, '0, 5'd16, 0, 0);
        send_chunk('1, '1, 5'd16, 0, 0);
        send_chunk(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd0, 0, 0);
        send_chunk('1, '1, 5'd17, 0, 0);
        send_chunk('1, '1, 5'd31, 0, 0);
        send_chunk('1, '1, 5'd1, 0, 0);
        send_chunk('1, '1, 5'd8, 0, 0);
        send_chunk('1, '1, 5'd9, 0, 0);
        drain();

        // standard test vector key, counter about to wrap
        write_cfg(aes_ctr_pkg::REG_KEY_UPPER, 64'h2b7e151628aed2a6);
        write_cfg(aes_ctr_pkg::REG_KEY_LOWER, 64'habf7158809cf4f3c);
        write_cfg(aes_ctr_pkg::REG_IV_UPPER, '1);
        write_cfg(aes_ctr_pkg::REG_IV_LOWER, 64'hffff_ffff_ffff_fffe);
        send_chunk(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1, 0);
        send_chunk('1, '1, 5'd16, 0, 0);
        send_chunk('0, '0, 5'd16, 0, 0);
        send_chunk('1, '1, 5'd15, 0, 0);
        send_chunk('1, '1, 5'd2, 1, 0);
        drain();
        write_cfg(aes_ctr_pkg::REG_IV_UPPER, '0);
        write_cfg(aes_ctr_pkg::REG_IV_LOWER, 64'hffff_ffff_ffff_ffff);
        send_chunk('1, '0, 5'd16, 1, 0);
        send_chunk('0, '1, 5'd16, 0, 0);
        send_chunk('1, '1, 5'd3, 1, 0);
        drain();

        // random phases with varied settings; long receiver hold-off in the middle
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(aes_ctr_pkg::REG_KEY_UPPER, ph == 5 ? '1 : rand64());
            write_cfg(aes_ctr_pkg::REG_KEY_LOWER, ph == 5 ? '1 : rand64());
            write_cfg(aes_ctr_pkg::REG_IV_UPPER, ph == 4 ? '1 : rand64());
            write_cfg(aes_ctr_pkg::REG_IV_LOWER,
                      ph == 4 ? 64'hffff_ffff_ffff_fff0 : rand64());
            for (int i = 0; i < 230; i++) begin
                if (ph == 2 && i == 50) begin
                    rx_hold = 1;
                    fork
                        begin repeat (300) @(posedge aclk); rx_hold = 0; end
                    join_none
                end
                if (ph == 3 && i == 100) drain();
                if ($urandom_range(0, 2) == 0) random_chunk(0);
                else random_chunk($urandom_range(0, 13));
            end
            drain();
        end

        $display("covered %0d chunks, %0d results checked: lengths 0..31, counter wrap,",
                 chunks_sent, sb.checked);
        $display("restarts, key/IV extremes, input backpressure and long output stalls");
        if (sb.errors == 0 && sb.pending_text.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
